// ----- hw/rtl/ppp_pkg.sv -----
package ppp_pkg;

	localparam int DEF_MAX_PARTICLES = 4096;

	localparam int IDX_W   = 12;
	localparam int COORD_W = 14;
	localparam int WORD_W  = 3 * COORD_W;
	localparam int QUO_W   = 27;
	localparam int DEN_W   = 13;

	localparam logic [COORD_W-1:0] HALF_RANGE       = 14'h2000;
	localparam logic signed [34:0] RADIUS_SQ        = 35'sh4000000;
	localparam logic signed [16:0] MIN_DEPTH        = 17'sd4;
	localparam int                 COLOR_BASE_SHIFT = 8;
	localparam logic [1:0]         MAX_COLOR_SHIFT  = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [1:0] BLEND_NONE = 2'd3;

	localparam logic [2:0] CFG_VIEW_WIDTH    = 3'd0;
	localparam logic [2:0] CFG_VIEW_HEIGHT   = 3'd1;
	localparam logic [2:0] CFG_FALL_SPEED    = 3'd2;
	localparam logic [2:0] CFG_BASE_COLOR    = 3'd3;
	localparam logic [2:0] CFG_COLOR_SHIFT   = 3'd4;
	localparam logic [2:0] CFG_BLEND_MODE    = 3'd5;
	localparam logic [2:0] CFG_DRAW_DISABLED = 3'd6;

	typedef struct packed {
		logic             op;
		logic             ok;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	typedef struct packed {
		logic               live;
		logic [DEN_W-1:0]   depth;
		logic signed [13:0] v4;
		logic signed [13:0] v7;
		logic signed [15:0] hz;
	} div_tag_t;

	typedef struct packed {
		logic        valid;
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  color;
		logic [1:0]  blend;
	} pix_t;

	// Difference of two wrapped coordinates, recentred around zero.
	function automatic logic signed [COORD_W-1:0] centred(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		logic [COORD_W-1:0] d;
		d = a - b;
		return signed'(d ^ HALF_RANGE);
	endfunction

endpackage

// ----- hw/rtl/ppp_ifs.sv -----
interface ppp_item_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [11:0]        particle_index;
	logic [13:0]        seed_x;
	logic [13:0]        seed_y;
	logic [13:0]        seed_z;
	logic [12:0]        camera_x;
	logic [12:0]        camera_y;
	logic [16:0]        camera_z;
	logic signed [15:0] angle_cos;
	logic signed [15:0] angle_sin;
	logic signed [15:0] horizon_row;

	modport source(output valid, opcode, particle_index, seed_x, seed_y, seed_z,
		camera_x, camera_y, camera_z, angle_cos, angle_sin, horizon_row, input ready);
	modport sink(input valid, opcode, particle_index, seed_x, seed_y, seed_z,
		camera_x, camera_y, camera_z, angle_cos, angle_sin, horizon_row, output ready);
endinterface

interface ppp_pix_if;
	logic        valid;
	logic        ready;
	logic        pixel_valid;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [7:0]  pixel_color;
	logic [1:0]  pixel_blend;

	modport source(output valid, pixel_valid, pixel_x, pixel_y, pixel_color, pixel_blend,
		input ready);
	modport sink(input valid, pixel_valid, pixel_x, pixel_y, pixel_color, pixel_blend,
		output ready);
endinterface

interface ppp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [13:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ppp_table.sv -----
module ppp_table
	import ppp_pkg::*;
#(
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
	localparam int AW = $clog2(MAX_PARTICLES)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [MAX_PARTICLES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/ppp_div.sv -----
module ppp_div
	import ppp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [QUO_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  div_tag_t         tag_in,
	output logic             out_valid,
	output logic [QUO_W-1:0] quo,
	output div_tag_t         tag_out
);

	logic             vld_q [QUO_W];
	logic [DEN_W-1:0] rem_q [QUO_W];
	logic [QUO_W-1:0] quo_q [QUO_W];
	logic [QUO_W-1:0] num_q [QUO_W];
	logic [DEN_W-1:0] den_q [QUO_W];
	div_tag_t         tag_q [QUO_W];

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic             v_in;
		logic [DEN_W-1:0] rem_in;
		logic [QUO_W-1:0] quo_in;
		logic [QUO_W-1:0] num_in;
		logic [DEN_W-1:0] den_in;
		div_tag_t         tag_i;
		logic [DEN_W:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num;
			assign den_in = den;
			assign tag_i  = tag_in;
		end else begin : g_next
			assign v_in   = vld_q[k-1];
			assign rem_in = rem_q[k-1];
			assign quo_in = quo_q[k-1];
			assign num_in = num_q[k-1];
			assign den_in = den_q[k-1];
			assign tag_i  = tag_q[k-1];
		end

		assign trial = {rem_in, num_in[QUO_W-1-k]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
				quo_q[k] <= {quo_in[QUO_W-2:0], take};
				num_q[k] <= num_in;
				den_q[k] <= den_in;
				tag_q[k] <= tag_i;
			end
		end
	end

	assign out_valid = vld_q[QUO_W-1];
	assign quo       = quo_q[QUO_W-1];
	assign tag_out   = tag_q[QUO_W-1];

endmodule

// ----- hw/rtl/particle_point_projector_unit.sv -----
// A word passes through stages 1 to 5, the divider, the projection registers and the
// output word register before its pixel word is offered at the output.
// Throughput: one word per cycle while the output skid entry is empty, set by the
// separate table read and write ports and the 27-stage divider. A word whose particle
// index matches one of the up to five words between table read and table write-back
// waits until that write is done. Reset clears the control state and loads the register
// defaults; the particle table holds unknown data until each entry is loaded.
module particle_point_projector_unit
	import ppp_pkg::*;
#(
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
	input logic         clk,
	input logic         arst_n,
	ppp_item_if.sink    items,
	ppp_pix_if.source   pixels,
	ppp_cfg_if.sink     cfg
);

	localparam int AW = $clog2(MAX_PARTICLES);

	// Configuration registers.
	logic [11:0] vw_q, vh_q;
	logic [13:0] fall_q;
	logic [7:0]  base_q;
	logic [1:0]  cshift_q, blend_q;
	logic        dd_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q     <= 12'd320;
			vh_q     <= 12'd200;
			fall_q   <= '0;
			base_q   <= '0;
			cshift_q <= '0;
			blend_q  <= '0;
			dd_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_VIEW_WIDTH:    vw_q     <= cfg.data[11:0];
				CFG_VIEW_HEIGHT:   vh_q     <= cfg.data[11:0];
				CFG_FALL_SPEED:    fall_q   <= cfg.data;
				CFG_BASE_COLOR:    base_q   <= cfg.data[7:0];
				CFG_COLOR_SHIFT:   cshift_q <= cfg.data[1:0];
				CFG_BLEND_MODE:    blend_q  <= cfg.data[1:0];
				CFG_DRAW_DISABLED: dd_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control.
	logic adv, hazard, take_in, skid_valid_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	assign adv = !skid_valid_q;

	// Interlock against words whose table write-back is still pending.
	assign hazard = (v_s1 && ctl_s1.idx == items.particle_index) ||
		(v_s2 && ctl_s2.idx == items.particle_index) ||
		(v_s3 && ctl_s3.idx == items.particle_index) ||
		(v_s4 && ctl_s4.idx == items.particle_index) ||
		(v_s5 && ctl_s5.idx == items.particle_index);

	assign items.ready = adv && !hazard;
	assign take_in     = items.valid && items.ready;

	logic [16:0]       idx_ext, wr_idx_ext;
	logic [WORD_W-1:0] rd_data, wr_data;
	logic              wr_en;

	assign idx_ext    = 17'(items.particle_index);
	assign wr_idx_ext = 17'(ctl_s5.idx);

	ppp_table #(.MAX_PARTICLES(MAX_PARTICLES)) u_table (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (idx_ext[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_ext[AW-1:0]),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: table read in flight.
	logic [13:0]        sx_s1, sy_s1, sz_s1;
	logic [12:0]        cx_s1, cy_s1;
	logic [16:0]        cz_s1;
	logic signed [15:0] cs_s1, sn_s1, hz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.op  <= items.opcode;
			ctl_s1.ok  <= idx_ext < 17'(MAX_PARTICLES);
			ctl_s1.idx <= items.particle_index;
			sx_s1      <= items.seed_x;
			sy_s1      <= items.seed_y;
			sz_s1      <= items.seed_z;
			cx_s1      <= items.camera_x;
			cy_s1      <= items.camera_y;
			cz_s1      <= items.camera_z;
			cs_s1      <= items.angle_cos;
			sn_s1      <= items.angle_sin;
			hz_s1      <= items.horizon_row;
		end
	end

	// Stage 2: offsets from the camera.
	logic [13:0]        rx, ry, rz;
	logic [13:0]        x_s2, y_s2, z_s2;
	logic signed [13:0] v1_s2, v2_s2, v7_s2;
	logic signed [15:0] cs_s2, sn_s2, hz_s2;

	assign rx = rd_data[41:28];
	assign ry = rd_data[27:14];
	assign rz = rd_data[13:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
			x_s2   <= (ctl_s1.op == OP_LOAD) ? sx_s1 : rx;
			y_s2   <= (ctl_s1.op == OP_LOAD) ? sy_s1 : ry;
			z_s2   <= (ctl_s1.op == OP_LOAD) ? sz_s1 : rz;
			v1_s2  <= centred(ry, {cx_s1, 1'b0});
			v2_s2  <= centred(rx, {cy_s1, 1'b0});
			v7_s2  <= centred(cz_s1[16:3], rz);
			cs_s2  <= cs_s1;
			sn_s2  <= sn_s1;
			hz_s2  <= hz_s1;
		end
	end

	// Stage 3: rotation products.
	logic [13:0]        x_s3, y_s3, z_s3;
	logic signed [13:0] v7_s3;
	logic signed [15:0] hz_s3;
	logic signed [29:0] p1_s3, p2_s3, p3_s3, p4_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= ctl_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			v7_s3  <= v7_s2;
			hz_s3  <= hz_s2;
			p1_s3  <= v1_s2 * cs_s2;
			p2_s3  <= v2_s2 * sn_s2;
			p3_s3  <= v2_s2 * cs_s2;
			p4_s3  <= v1_s2 * sn_s2;
		end
	end

	// Stage 4: depth and lateral offset.
	logic signed [30:0] dsum, lsum;
	logic [13:0]        x_s4, y_s4, z_s4;
	logic signed [13:0] v7_s4;
	logic signed [15:0] hz_s4;
	logic signed [16:0] v3_s4, v4_s4;

	assign dsum = 31'(p1_s3) + 31'(p2_s3);
	assign lsum = 31'(p3_s3) - 31'(p4_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			z_s4   <= z_s3;
			v7_s4  <= v7_s3;
			hz_s4  <= hz_s3;
			v3_s4  <= dsum[30:14];
			v4_s4  <= lsum[30:14];
		end
	end

	// Stage 5: radius test, table write-back and divider launch.
	logic [13:0]        x_s5, y_s5, z_s5;
	logic signed [13:0] v7_s5;
	logic signed [15:0] hz_s5;
	logic signed [16:0] v3_s5, v4_s5;
	logic signed [33:0] sq3_s5, sq4_s5;
	logic               dok_s5, cull_in, live;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5 <= ctl_s4;
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			z_s5   <= z_s4;
			v7_s5  <= v7_s4;
			hz_s5  <= hz_s4;
			v3_s5  <= v3_s4;
			v4_s5  <= v4_s4;
			sq3_s5 <= v3_s4 * v3_s4;
			sq4_s5 <= v4_s4 * v4_s4;
			dok_s5 <= v3_s4 > MIN_DEPTH;
		end
	end

	assign cull_in = dok_s5 && (35'(sq3_s5) + 35'(sq4_s5) < RADIUS_SQ);
	assign live    = ctl_s5.op == OP_STEP && ctl_s5.ok && cull_in;
	assign wr_en   = adv && v_s5 && ctl_s5.ok && (ctl_s5.op == OP_LOAD || cull_in);
	assign wr_data = {x_s5, y_s5, (ctl_s5.op == OP_LOAD) ? z_s5 : z_s5 + fall_q};

	div_tag_t         tag_s5, dtag;
	logic             dvalid;
	logic [QUO_W-1:0] dquo;

	assign tag_s5 = '{live: live, depth: v3_s5[DEN_W-1:0], v4: v4_s5[13:0], v7: v7_s5,
		hz: hz_s5};

	ppp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.num       ({vw_q, 15'd0}),
		.den       (v3_s5[DEN_W-1:0]),
		.tag_in    (tag_s5),
		.out_valid (dvalid),
		.quo       (dquo),
		.tag_out   (dtag)
	);

	// Projection products, then screen position.
	logic               v_d1, v_d2;
	div_tag_t           tag_d1, tag_d2;
	logic signed [41:0] m6_d1, m8_d1;
	logic signed [27:0] v6_d2, v8_d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
		end else if (adv) begin
			v_d1 <= dvalid;
			v_d2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_d1 <= dtag;
			m6_d1  <= dtag.v4 * signed'({1'b0, dquo});
			m8_d1  <= dtag.v7 * signed'({1'b0, dquo});
			tag_d2 <= tag_d1;
			v6_d2  <= 28'(signed'(m6_d1[41:16])) + 28'(signed'({1'b0, vw_q[11:1]}));
			v8_d2  <= 28'(tag_d1.hz) + 28'(signed'(m8_d1[41:16]));
		end
	end

	logic        x_in, y_in, pix_ok;
	logic [1:0]  csat;
	logic [12:0] shade;
	pix_t        res;

	assign x_in   = !v6_d2[27] && (v6_d2[26:0] < 27'(vw_q));
	assign y_in   = !v8_d2[27] && (v8_d2[26:0] < 27'(vh_q));
	assign pix_ok = tag_d2.live && x_in && y_in && !dd_q && blend_q != BLEND_NONE;
	assign csat   = (cshift_q > MAX_COLOR_SHIFT) ? MAX_COLOR_SHIFT : cshift_q;
	assign shade  = tag_d2.depth >> (COLOR_BASE_SHIFT + int'(csat));

	always_comb begin
		res = '0;
		if (pix_ok) begin
			res.valid = 1'b1;
			res.x     = v6_d2[11:0];
			res.y     = v8_d2[11:0];
			res.color = base_q - shade[7:0];
			res.blend = blend_q;
		end
	end

	// Output word register with one skid entry behind it.
	logic push, pop, out_valid_q;
	pix_t out_q, skid_q;

	assign push = adv && v_d2;
	assign pop  = out_valid_q && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.pixel_valid = out_q.valid;
	assign pixels.pixel_x     = out_q.x;
	assign pixels.pixel_y     = out_q.y;
	assign pixels.pixel_color = out_q.color;
	assign pixels.pixel_blend = out_q.blend;

endmodule
